// ===== src/ftbf_pkg.sv =====
// shared constants and field layout for the five-tuple blocklist filter
package ftbf_pkg;

    localparam int MAX_RULES_DEF = 64;
    localparam int IDX_EXT_W     = 11;

    localparam int RULE_COUNT_W = 7;
    localparam int SLOT_W       = 6;
    localparam int ADDR_W       = 32;
    localparam int PORT_W       = 16;
    localparam int PROTO_W      = 8;
    localparam int VERDICT_W    = 2;

    localparam int ADDRS_W = 2 * ADDR_W;
    localparam int PPR_W   = 2 * PORT_W + PROTO_W;

    localparam int SLOT_LSB  = 0;
    localparam int SRC_LSB   = SLOT_LSB + SLOT_W;
    localparam int DST_LSB   = SRC_LSB + ADDR_W;
    localparam int SPORT_LSB = DST_LSB + ADDR_W;
    localparam int DPORT_LSB = SPORT_LSB + PORT_W;
    localparam int PROTO_LSB = DPORT_LSB + PORT_W;
    localparam int S_FIELDS_W = PROTO_LSB + PROTO_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int TUSER_OPCODE = 0;
    localparam int TUSER_HDR    = 1;
    localparam int S_TUSER_W    = 2;

    localparam int M_TDATA_W = 8;

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP    = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_WRITTEN = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'd3;

endpackage

// ===== src/ftbf_ram.sv =====
// generic simple dual-port ram with registered read
module ftbf_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/five_tuple_blocklist_filter.sv =====
// top level of the five-tuple blocklist filter
// Each input word is either a rule write (tuser bit 0 high) that stores a five-tuple at
// rule_slot, or a packet header to classify. One word is handled at a time: the block takes
// a word, works on it, and is ready again after its verdict is loaded into the output
// register (the output may still be waiting on m_tready). After a rule write, or a packet
// that is neither TCP nor UDP or has no IP header, the verdict is set at once with no
// scan. A TCP or UDP packet walks the rule table through the read ports of its two rams,
// one rule per cycle, over the first min(rule_count, MAX_RULES) rules, and stops early
// when a rule hits. The rule table has no reset and needs no clearing pass; rules must be
// written before rule_count covers them.
module five_tuple_blocklist_filter #(
    parameter int MAX_RULES = ftbf_pkg::MAX_RULES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ftbf_pkg::RULE_COUNT_W-1:0] cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rule_slot, src_addr, dst_addr, source port, destination port, proto_num, zero pad
    input  logic [ftbf_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode, header_present
    input  logic [ftbf_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // verdict, zero pad
    output logic [ftbf_pkg::M_TDATA_W-1:0]    m_tdata
);

    import ftbf_pkg::*;

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [RULE_COUNT_W-1:0] rule_count_reg, rule_count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           limit_reg, limit_next;
    logic                    pend_reg, pend_next;
    logic [VERDICT_W-1:0]    verdict_reg, verdict_next;
    logic                    m_valid_reg, m_valid_next;
    logic [VERDICT_W-1:0]    m_verdict_reg, m_verdict_next;
    logic [ADDRS_W-1:0]      key_addrs_reg, key_addrs_next;
    logic [PPR_W-1:0]        key_ppr_reg, key_ppr_next;

    logic                    s_accept;
    logic                    in_opcode;
    logic                    in_hdr;
    logic [SLOT_W-1:0]       in_slot;
    logic [PROTO_W-1:0]      in_proto;
    logic [ADDRS_W-1:0]      in_addrs;
    logic [PPR_W-1:0]        in_ppr;
    logic [IDX_EXT_W-1:0]    slot_ext;
    logic [IDX_EXT_W-1:0]    count_ext;
    logic                    wr_en;
    logic                    rd_en;
    logic [ADDRS_W-1:0]      rd_addrs;
    logic [PPR_W-1:0]        rd_ppr;
    logic                    hit;

    assign in_opcode = s_tuser[TUSER_OPCODE];
    assign in_hdr    = s_tuser[TUSER_HDR];
    assign in_slot   = s_tdata[SLOT_LSB +: SLOT_W];
    assign in_proto  = s_tdata[PROTO_LSB +: PROTO_W];
    assign in_addrs  = {s_tdata[SRC_LSB +: ADDR_W], s_tdata[DST_LSB +: ADDR_W]};
    assign in_ppr    = {s_tdata[SPORT_LSB +: PORT_W], s_tdata[DPORT_LSB +: PORT_W], in_proto};

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign slot_ext  = IDX_EXT_W'(in_slot);
    assign count_ext = IDX_EXT_W'(rule_count_reg);
    assign wr_en     = s_accept && (in_opcode == OP_WRITE)
                       && (slot_ext < IDX_EXT_W'(MAX_RULES));

    assign hit = pend_reg && (rd_addrs == key_addrs_reg) && (rd_ppr == key_ppr_reg);
    assign rd_en = (state_reg == ST_SCAN) && !hit && (idx_reg != limit_reg);

    ftbf_ram #(
        .WIDTH (ADDRS_W),
        .DEPTH (MAX_RULES),
        .ADDR_W(AW)
    ) u_addrs_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(slot_ext[AW-1:0]),
        .wr_data(in_addrs),
        .rd_en  (rd_en),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(rd_addrs)
    );

    ftbf_ram #(
        .WIDTH (PPR_W),
        .DEPTH (MAX_RULES),
        .ADDR_W(AW)
    ) u_ppr_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(slot_ext[AW-1:0]),
        .wr_data(in_ppr),
        .rd_en  (rd_en),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(rd_ppr)
    );

    always_comb begin
        state_next      = state_reg;
        rule_count_next = rule_count_reg;
        idx_next        = idx_reg;
        limit_next      = limit_reg;
        pend_next       = 1'b0;
        verdict_next    = verdict_reg;
        m_valid_next    = m_valid_reg;
        m_verdict_next  = m_verdict_reg;
        key_addrs_next  = key_addrs_reg;
        key_ppr_next    = key_ppr_reg;

        if (cfg_wr_en) begin
            rule_count_next = cfg_wr_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    key_addrs_next = in_addrs;
                    key_ppr_next   = in_ppr;
                    idx_next       = '0;
                    if (count_ext > IDX_EXT_W'(MAX_RULES)) begin
                        limit_next = CW'(MAX_RULES);
                    end else begin
                        limit_next = count_ext[CW-1:0];
                    end
                    if (in_opcode == OP_WRITE) begin
                        verdict_next = VERDICT_WRITTEN;
                        state_next   = ST_DONE;
                    end else if (in_hdr && (in_proto == PROTO_TCP || in_proto == PROTO_UDP)) begin
                        state_next = ST_SCAN;
                    end else begin
                        verdict_next = VERDICT_ACCEPT;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    verdict_next = VERDICT_DROP;
                    state_next   = ST_DONE;
                end else if (idx_reg == limit_reg) begin
                    verdict_next = VERDICT_ACCEPT;
                    state_next   = ST_DONE;
                end else begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_verdict_next = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rule_count_reg <= '0;
            idx_reg        <= '0;
            limit_reg      <= '0;
            pend_reg       <= 1'b0;
            verdict_reg    <= VERDICT_ACCEPT;
            m_valid_reg    <= 1'b0;
            m_verdict_reg  <= VERDICT_ACCEPT;
        end else begin
            state_reg      <= state_next;
            rule_count_reg <= rule_count_next;
            idx_reg        <= idx_next;
            limit_reg      <= limit_next;
            pend_reg       <= pend_next;
            verdict_reg    <= verdict_next;
            m_valid_reg    <= m_valid_next;
            m_verdict_reg  <= m_verdict_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_addrs_reg <= key_addrs_next;
        key_ppr_reg   <= key_ppr_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_verdict_reg);

endmodule

// ===== src/ftbf_checker.sv =====
// port-level checks for the five-tuple blocklist filter, bound to the top level
module ftbf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [ftbf_pkg::S_TUSER_W-1:0]    s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ftbf_pkg::M_TDATA_W-1:0]    m_tdata
);

    import ftbf_pkg::*;

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    // output word holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // a verdict is accept, drop or written, pad bits zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VERDICT_W-1:0] != VERDICT_NONE)
                     && (m_tdata[M_TDATA_W-1:VERDICT_W] == '0))
        else $error("bad verdict code");

    // a rule write into a free output is answered with written once the done state loads the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser[TUSER_OPCODE] == OP_WRITE) && !m_tvalid |->
            ##2 (m_tvalid && (m_tdata[VERDICT_W-1:0] == VERDICT_WRITTEN)))
        else $error("rule write not answered");

    // a packet without ip header is accepted without a scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser[TUSER_OPCODE] == OP_CLASSIFY) && !s_tuser[TUSER_HDR]
            && !m_tvalid |->
            ##2 (m_tvalid && (m_tdata[VERDICT_W-1:0] == VERDICT_ACCEPT)))
        else $error("headerless packet not accepted");

endmodule

bind five_tuple_blocklist_filter ftbf_checker u_ftbf_checker (.*);
